// ----- rtl/pair_sorter_asc_primary_desc_secondary_top_assert.svh -----
// ---------------------------------------------------------------------------
// Pair sorter assertion macros
// Shared forms for the concurrent checks of the pair sorter.
// ---------------------------------------------------------------------------
`ifndef PAIR_SORTER_ASC_PRIMARY_DESC_SECONDARY_TOP_ASSERT_SVH
`define PAIR_SORTER_ASC_PRIMARY_DESC_SECONDARY_TOP_ASSERT_SVH

// A check that must hold at every edge outside reset.
`define PS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A check that a trigger implies a consequence in the following cycle.
`define PS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pairsort_pkg.sv -----
// ---------------------------------------------------------------------------
// Pair sorter package
// Word types and the ordering function shared by the sorter modules.
// ---------------------------------------------------------------------------
package pairsort_pkg;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // One stored pair.
  typedef struct packed {
    logic signed [31:0] key_primary;
    logic signed [31:0] key_secondary;
  } pair_t;

  // Input word.
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key_primary;
    logic signed [31:0] key_secondary;
  } req_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] out_primary;
    logic signed [31:0] out_secondary;
    logic               empty_res;
    logic               overflowed;
  } res_t;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // True when pair a must be placed strictly ahead of pair b:
  // ascending first key, then descending second key.
  function automatic logic goes_before(pair_t a, pair_t b);
    logic lt_p;
    logic eq_p;
    lt_p = (a.key_primary < b.key_primary);
    eq_p = (a.key_primary == b.key_primary);
    return lt_p || (eq_p && (b.key_secondary < a.key_secondary));
  endfunction

endpackage

// ----- rtl/pairsort_if.sv -----
// ---------------------------------------------------------------------------
// Pair sorter stream interfaces
// Valid/ready channels for request words and result words.
// ---------------------------------------------------------------------------
interface pairsort_req_if;
  import pairsort_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pairsort_res_if;
  import pairsort_pkg::*;

  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pairsort_cell.sv -----
// ---------------------------------------------------------------------------
// Pair sorter cell
// One slot of the sorted chain: compares the incoming pair with its own and
// shifts towards the tail on a push or towards the head on a pop.
// ---------------------------------------------------------------------------
module pairsort_cell (
  input  logic                     clk_i,
  input  pairsort_pkg::cell_ctrl_t ctrl_i,
  input  logic                     occupied_i,
  input  pairsort_pkg::pair_t      new_pair_i,
  input  pairsort_pkg::pair_t      left_pair_i,
  input  logic                     left_ins_i,
  input  pairsort_pkg::pair_t      right_pair_i,
  output pairsort_pkg::pair_t      pair_o,
  output logic                     ins_o
);
  import pairsort_pkg::*;

  pair_t pair_q;
  pair_t pair_d;

  // The new pair belongs at or before this slot when the slot is empty or
  // the new pair sorts strictly ahead of the one held here.
  assign ins_o = !occupied_i || goes_before(new_pair_i, pair_q);

  // A push makes room by taking the left word; the first slot to give way
  // takes the new pair. A pop pulls the right word towards the head.
  always_comb begin
    pair_d = pair_q;
    if (ctrl_i.push) begin
      if (ins_o) begin
        pair_d = left_ins_i ? left_pair_i : new_pair_i;
      end
    end else if (ctrl_i.pop) begin
      pair_d = right_pair_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign pair_o = pair_q;

endmodule

// ----- rtl/pair_sorter_asc_primary_desc_secondary_top.sv -----
// ---------------------------------------------------------------------------
// Pair sorter top level
// Sorted store of signed pairs with push and pop requests.
// ---------------------------------------------------------------------------
// The block takes one request word per clock cycle, push or pop alike: every
// cell of the chain compares its pair with the incoming one and shifts in the
// same cycle, so the cell compare and the shift between neighbours set the
// cycle. A pop's result enters the output register in the cycle after it is
// accepted; while that result waits to be taken, no request is accepted. A
// push to a full store is dropped and reported on the next pop, and a pop of
// an empty store returns zeros with the empty flag set. Reset leaves the store
// empty at once, with no clearing pass.
// ---------------------------------------------------------------------------
module pair_sorter_asc_primary_desc_secondary_top #(
  parameter int MAX_PAIRS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pairsort_req_if.sink         req_i,
  pairsort_res_if.source       res_o
);
  import pairsort_pkg::*;

  localparam int CntW = $clog2(MAX_PAIRS + 1);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            drop_q;
  logic            drop_d;
  logic            res_valid_q;
  logic            res_valid_d;
  res_t            res_q;
  res_t            res_d;

  logic            req_fire;
  logic            is_push;
  logic            is_pop;
  logic            full;
  logic            nonempty;
  cell_ctrl_t      ctrl;
  pair_t           new_pair;

  pair_t           cell_pair [MAX_PAIRS];
  logic            cell_ins  [MAX_PAIRS];
  logic            cell_occ  [MAX_PAIRS];

  // Handshake: a new word enters when the result register is free or emptying.
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_push     = req_fire && (req_i.payload.req_type == REQ_PUSH);
  assign is_pop      = req_fire && (req_i.payload.req_type == REQ_POP);
  assign full        = (count_q == CntW'(MAX_PAIRS));
  assign nonempty    = (count_q != '0);

  assign new_pair.key_primary   = req_i.payload.key_primary;
  assign new_pair.key_secondary = req_i.payload.key_secondary;

  // A push to a full store leaves the chain untouched.
  assign ctrl.push = is_push && !full;
  assign ctrl.pop  = is_pop && nonempty;

  // The chain of cells; occupied slots always form a prefix.
  for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
    pair_t left_pair;
    pair_t right_pair;
    logic  left_ins;

    assign cell_occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_pair = new_pair;
      assign left_ins  = 1'b0;
    end else begin : g_body
      assign left_pair = cell_pair[i-1];
      assign left_ins  = cell_ins[i-1];
    end

    if (i == MAX_PAIRS - 1) begin : g_tail
      assign right_pair = cell_pair[i];
    end else begin : g_inner
      assign right_pair = cell_pair[i+1];
    end

    pairsort_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (cell_occ[i]),
      .new_pair_i   (new_pair),
      .left_pair_i  (left_pair),
      .left_ins_i   (left_ins),
      .right_pair_i (right_pair),
      .pair_o       (cell_pair[i]),
      .ins_o        (cell_ins[i])
    );
  end

  // Fill count, drop flag and result register.
  always_comb begin
    count_d     = count_q;
    drop_d      = drop_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_d       = res_q;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end
    if (is_push && full) begin
      drop_d = 1'b1;
    end
    if (is_pop) begin
      drop_d           = 1'b0;
      res_valid_d      = 1'b1;
      res_d.overflowed = drop_q;
      res_d.empty_res  = !nonempty;
      if (nonempty) begin
        res_d.out_primary   = cell_pair[0].key_primary;
        res_d.out_secondary = cell_pair[0].key_secondary;
        count_d             = count_q - CntW'(1);
      end else begin
        res_d.out_primary   = '0;
        res_d.out_secondary = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drop_q      <= drop_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  // Checks on the fill count, the head ordering, the empty pop result and the dropped push.
`include "pair_sorter_asc_primary_desc_secondary_top_assert.svh"

  `PS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MAX_PAIRS), "fill count above capacity")
  `PS_ASSERT_ALWAYS(a_head_order, clk_i, rst_ni, !cell_occ[1] || !goes_before(cell_pair[1], cell_pair[0]), "first two slots out of order")
  `PS_ASSERT_NEXT(a_empty_pop, clk_i, rst_ni, is_pop && !nonempty, res_valid_q && res_q.empty_res && count_q == '0, "empty pop not reported")
  `PS_ASSERT_NEXT(a_full_drop, clk_i, rst_ni, is_push && full, drop_q && count_q == CntW'(MAX_PAIRS), "dropped push changed the store")

endmodule

// ----- bench/pair_sorter_asc_primary_desc_secondary_top_tb.sv -----
// ---------------------------------------------------------------------------
// Pair sorter regression bench
// Drives push and pop request words into the sorter and compares every
// result word against the directed table's word or a behavioural copy of
// the sorted store. The bench runs a directed table first, then fills the
// store past capacity and drains it with the receiver held off for a long
// stretch at first, and then runs random data sets and noise. The sender
// works in bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module pair_sorter_asc_primary_desc_secondary_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pairsort_pkg::*;

  localparam int          CLK_PERIOD  = 4;
  localparam int          STORE_DEPTH = 256;
  localparam int          WORD_TARGET = 1150;
  localparam int          HOLD_CYCLES = 150;
  localparam int          CYCLE_LIMIT = 300000;
  localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;

  // One row of the directed table.
  typedef struct {
    logic               req;
    logic signed [31:0] kp;
    logic signed [31:0] ks;
    bit                 typed;
    res_t               want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;

  pairsort_req_if req_ch ();
  pairsort_res_if res_ch ();

  pair_sorter_asc_primary_desc_secondary_top #(
    .MAX_PAIRS(STORE_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch)
  );

  // Behavioural copy of the store and the scoreboard.
  pair_t       held_pairs[$];
  bit          drop_pending;
  res_t        pending_pops[$];
  step_row_t   directed_rows[$];
  bit          cur_typed;
  res_t        cur_want;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned burst_left;
  bit          steady_run;
  bit          hold_request;
  int unsigned push_count;
  int unsigned pop_count;
  int unsigned empty_seen;
  int unsigned drop_seen;
  int unsigned peak_fill;

  // Clock.
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // True when pair a belongs strictly ahead of pair b in the sorted order.
  function automatic bit ahead_of(pair_t a, pair_t b);
    if ($signed(a.key_primary) != $signed(b.key_primary)) begin
      return $signed(a.key_primary) < $signed(b.key_primary);
    end
    return $signed(b.key_secondary) < $signed(a.key_secondary);
  endfunction

  // Applies one request word to the store copy and returns its result word.
  task automatic sort_model_step(input req_t w, output bit has_res, output res_t r);
    pair_t       np;
    int unsigned pos;
    has_res = 1'b0;
    r       = '0;
    if (w.req_type == REQ_PUSH) begin
      if (held_pairs.size() >= STORE_DEPTH) begin
        drop_pending = 1'b1;
      end else begin
        np.key_primary   = w.key_primary;
        np.key_secondary = w.key_secondary;
        pos = 0;
        while (pos < held_pairs.size() && !ahead_of(np, held_pairs[pos])) pos++;
        held_pairs.insert(pos, np);
        if (held_pairs.size() > peak_fill) peak_fill = held_pairs.size();
      end
    end else begin
      has_res      = 1'b1;
      r.overflowed = drop_pending;
      drop_pending = 1'b0;
      if (held_pairs.size() == 0) begin
        r.empty_res = 1'b1;
      end else begin
        r.out_primary   = held_pairs[0].key_primary;
        r.out_secondary = held_pairs[0].key_secondary;
        void'(held_pairs.pop_front());
      end
    end
  endtask

  // Key values biased towards ties, signs and the extremes.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 4))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return 32'd0;
          3:       return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic plan_row(input logic req, input logic [31:0] kp, input logic [31:0] ks,
                          input bit typed, input logic [31:0] wp, input logic [31:0] ws,
                          input logic we, input logic wo);
    step_row_t row;
    row.req  = req;
    row.kp   = kp;
    row.ks   = ks;
    row.typed = typed;
    row.want.out_primary   = wp;
    row.want.out_secondary = ws;
    row.want.empty_res     = we;
    row.want.overflowed    = wo;
    directed_rows.push_back(row);
  endtask

  // Offers one request word in the sender's burst pattern and waits for it.
  task automatic offer(input logic req, input logic [31:0] kp, input logic [31:0] ks,
                       input bit typed, input res_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) steady_run = !steady_run;
      gap = steady_run ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    req_ch.valid                 <= 1'b1;
    req_ch.payload.req_type      <= req;
    req_ch.payload.key_primary   <= kp;
    req_ch.payload.key_secondary <= ks;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk_i); while (!req_ch.ready);
    words_sent++;
  endtask

  // Scoreboard: check taken result words, then predict accepted requests.
  always @(posedge clk_i) begin : scoreboard
    res_t got;
    res_t want;
    res_t model_res;
    bit   has_res;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        if (got.empty_res)  empty_seen++;
        if (got.overflowed) drop_seen++;
        if (pending_pops.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          mismatches++;
        end else begin
          want = pending_pops.pop_front();
          if (got.out_primary !== want.out_primary) begin
            $display("%0t: out_primary expected %0d, got %0d", $time,
                     $signed(want.out_primary), $signed(got.out_primary));
            mismatches++;
          end
          if (got.out_secondary !== want.out_secondary) begin
            $display("%0t: out_secondary expected %0d, got %0d", $time,
                     $signed(want.out_secondary), $signed(got.out_secondary));
            mismatches++;
          end
          if (got.empty_res !== want.empty_res) begin
            $display("%0t: empty_res expected %b, got %b", $time,
                     want.empty_res, got.empty_res);
            mismatches++;
          end
          if (got.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %b, got %b", $time,
                     want.overflowed, got.overflowed);
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.payload.req_type == REQ_PUSH) push_count++;
        else pop_count++;
        sort_model_step(req_ch.payload, has_res, model_res);
        if (has_res) pending_pops.push_back(cur_typed ? cur_want : model_res);
      end
    end
  end

  // Receiver: stalls on a changing rotating mask, with one long hold-off
  // whenever the sender asks for it.
  initial begin : receiver
    logic [15:0] stall_pat;
    int unsigned pat_age;
    res_ch.ready = 1'b0;
    stall_pat    = '1;
    pat_age      = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (pat_age == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pat = '1;
            1:       stall_pat = 16'($urandom());
            2:       stall_pat = 16'($urandom() | $urandom());
            default: stall_pat = 16'($urandom() & $urandom());
          endcase
          if (stall_pat == '0) stall_pat = 16'h0001;
          pat_age = 48;
        end
        pat_age--;
        res_ch.ready <= stall_pat[0];
        stall_pat    = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("pair_sorter_asc_primary_desc_secondary_top regression: fail");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    res_t        no_want;
    int unsigned set_size;
    int unsigned extra;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rst_ni         = 1'b0;
    no_want        = '0;
    burst_left     = 0;
    steady_run     = 1'b0;
    hold_request   = 1'b0;
    drop_pending   = 1'b0;
    cur_typed      = 1'b0;
    cur_want       = '0;

    // Directed table: empty store, extremes in both keys, sign boundaries,
    // ties in the first key and fully equal pairs.
    plan_row(REQ_POP,  32'hDEAD_BEEF, 32'h1234_5678, 1, 0, 0, 1, 0);
    plan_row(REQ_PUSH, KEY_MAX, KEY_MIN, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, KEY_MIN, KEY_MIN, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, KEY_MIN, KEY_MAX, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, KEY_MIN, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, 32'hFFFF_FFFF, 7, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, 1, 7, 0, 0, 0, 0, 0);
    plan_row(REQ_POP,  KEY_MAX, KEY_MAX, 1, KEY_MIN, KEY_MAX, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, KEY_MIN, 0, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, KEY_MIN, KEY_MIN, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, 32'hFFFF_FFFF, 7, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, 0, 0, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, 0, 32'hFFFF_FFFF, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, 1, 7, 0, 0);
    plan_row(REQ_POP,  0, 0, 1, KEY_MAX, KEY_MIN, 0, 0);
    plan_row(REQ_POP,  KEY_MIN, KEY_MIN, 1, 0, 0, 1, 0);
    plan_row(REQ_PUSH, 5, 5, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, 5, 5, 0, 0, 0, 0, 0);
    plan_row(REQ_PUSH, 5, 6, 0, 0, 0, 0, 0);
    plan_row(REQ_POP,  0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_POP,  0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_POP,  0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_POP,  0, 0, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].kp, directed_rows[i].ks,
            directed_rows[i].typed, directed_rows[i].want);
    end

    // Fill the store past capacity so that inserts are dropped, then drain
    // it with the receiver held off at first so that the block backs up.
    repeat (STORE_DEPTH + 3) offer(REQ_PUSH, pick_key(), pick_key(), 0, no_want);
    hold_request = 1'b1;
    repeat (STORE_DEPTH + 2) offer(REQ_POP, $urandom(), $urandom(), 0, no_want);

    // Random data sets, mostly whole ones, with broken sets and noise.
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 10)) begin
            offer(1'($urandom_range(0, 1)), $urandom(), $urandom(), 0, no_want);
          end
        end
        2: begin
          set_size = $urandom_range(1, 16);
          repeat (set_size) offer(REQ_PUSH, pick_key(), pick_key(), 0, no_want);
          repeat ($urandom_range(0, set_size)) offer(REQ_POP, $urandom(), $urandom(), 0, no_want);
        end
        default: begin
          set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
          extra    = $urandom_range(0, 2);
          repeat (set_size) offer(REQ_PUSH, pick_key(), pick_key(), 0, no_want);
          repeat (set_size + extra) offer(REQ_POP, $urandom(), $urandom(), 0, no_want);
        end
      endcase
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    // Let every expected result word arrive, then give the block a short tail.
    while (pending_pops.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d request words: %0d inserts and %0d removals, peak fill %0d of %0d.",
             words_sent, push_count, pop_count, peak_fill, STORE_DEPTH);
    $display("Removals found the store empty %0d times and reported dropped inserts %0d times.",
             empty_seen, drop_seen);
    if (mismatches == 0) begin
      $display("pair_sorter_asc_primary_desc_secondary_top regression: pass");
    end else begin
      $display("pair_sorter_asc_primary_desc_secondary_top regression: fail");
    end
    $finish;
  end

endmodule
